// ----- hdl/rau_pkg.sv -----
// rau_pkg: shared types, constants and command structs for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    localparam int OperandWidth = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // datapath micro-operations
    typedef enum logic [3:0] {
        DC_NOP,
        DC_LOAD_A,    // p/q <- operand a
        DC_LOAD_B,    // p/q <- operand b
        DC_LOAD_INV,  // p/q <- inverse of b
        DC_GCD_INIT,  // x <- p, y <- q
        DC_DIV_INIT,  // start division
        DC_DIV_STEP,  // one restoring step
        DC_GCD_NEXT,  // x <- y, y <- rem
        DC_QNUM,      // latch p / g, start q / g
        DC_QDEN,      // latch q / g, finish canon into dest
        DC_MUL_P,     // product 1
        DC_MUL_Q,     // product 2
        DC_MUL_R,     // product 3 and combine
        DC_NEGATE     // result = -a
    } t_dcmd;

    typedef enum logic [1:0] {
        DST_A,
        DST_B,
        DST_R
    } t_dst;

    typedef struct packed {
        t_dcmd cmd;
        t_dst  dst;
        t_op   op;
    } t_ctl;

    typedef struct packed {
        logic       y_zero;   // gcd loop done
        logic       g_zero;   // gcd result zero
        logic       div_done;
        logic [1:0] canon_st; // status of last canon
    } t_sts;

endpackage

// ----- hdl/rau_if.sv -----
// rau_if: valid/ready channels, one carrying the request payload and one the result payload.
// Depends on nothing; payload fields are declared directly in each interface.
interface rau_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] res_num;
    logic [62:0] res_den;
    logic [1:0]  status;
    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ----- hdl/rau_datapath.sv -----
// rau_datapath: operand registers, shared restoring divider, 32x32 multiplier, canon logic.
// Depends on rau_pkg.
module rau_datapath (
    input  logic                 i_clk,
    input  rau_pkg::t_ctl        i_ctl,
    input  logic [31:0]          i_a_num,
    input  logic [31:0]          i_a_den,
    input  logic [31:0]          i_b_num,
    input  logic [31:0]          i_b_den,
    output rau_pkg::t_sts        o_sts,
    output logic signed [63:0]   o_res_num,
    output logic [62:0]          o_res_den
);
    import rau_pkg::*;

    logic [OperandWidth-1:0] r_bn, r_bd;
    logic        r_pneg, r_qneg;
    logic [63:0] r_p, r_q, r_x, r_y;
    logic [63:0] r_dvd, r_dvs, r_rem, r_quo;
    logic [6:0]  r_cnt;
    logic [63:0] r_gnum;
    logic        r_a_neg, r_b_neg, r_r_neg;
    logic [63:0] r_a_num, r_a_den, r_b_num, r_b_den, r_r_num, r_r_den;
    logic [63:0] r_t1;
    logic [1:0]  r_cst;

    function automatic logic [32:0] f_sx(input logic [31:0] v);
        logic [31:0] m;
        logic        s;
        m = v & ((32'd1 << OperandWidth) - 32'd1);
        if (OperandWidth < 32) m = v & ((32'd1 << (OperandWidth % 32)) - 32'd1);
        s = m[OperandWidth-1];
        if (s) m = (32'd0 - m) & ((OperandWidth == 32) ? 32'hFFFF_FFFF
                                   : ((32'd1 << (OperandWidth % 32)) - 32'd1));
        return {s, m};
    endfunction

    logic [32:0] w_in_an, w_in_ad, w_bn, w_bd;
    assign w_in_an = f_sx(i_a_num);
    assign w_in_ad = f_sx(i_a_den);
    assign w_bn = f_sx(r_bn);
    assign w_bd = f_sx(r_bd);

    logic [64:0] w_trial;
    assign w_trial = {r_rem[62:0], r_dvd[63 - r_cnt[5:0]], 1'b0} >> 1;
    logic [64:0] w_sub;
    assign w_sub = {1'b0, w_trial[63:0]} - {1'b0, r_dvs};

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic w_n2;
    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        unique case (i_ctl.cmd)
            DC_MUL_P: begin
                w_ma = r_a_den[31:0];
                w_mb = r_b_den[31:0];
            end
            DC_MUL_Q: begin
                w_ma = r_a_num[31:0];
                w_mb = (i_ctl.op == OP_MUL || i_ctl.op == OP_DIV) ? r_b_num[31:0]
                                                                  : r_b_den[31:0];
            end
            DC_MUL_R: begin
                w_ma = r_b_num[31:0];
                w_mb = r_a_den[31:0];
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end
    assign w_n2 = r_b_neg ^ (i_ctl.op == OP_SUB);

    logic w_cneg;
    assign w_cneg = (r_pneg != (r_qneg && r_q != 64'd0)) && r_gnum != 64'd0;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            DC_NOP: begin
            end
            DC_LOAD_A: begin
                r_bn <= i_b_num;
                r_bd <= i_b_den;
                r_pneg <= w_in_an[32];
                r_p    <= {32'd0, w_in_an[31:0]};
                r_qneg <= w_in_ad[32];
                r_q    <= {32'd0, w_in_ad[31:0]};
            end
            DC_LOAD_B: begin
                r_pneg <= w_bn[32];
                r_p    <= {32'd0, w_bn[31:0]};
                r_qneg <= w_bd[32];
                r_q    <= {32'd0, w_bd[31:0]};
            end
            DC_LOAD_INV: begin
                r_pneg <= r_b_den != 64'd0;
                r_p    <= r_b_den;
                r_qneg <= !r_b_neg && r_b_num != 64'd0;
                r_q    <= r_b_num;
            end
            DC_GCD_INIT: begin
                r_x <= r_p;
                r_y <= r_q;
            end
            DC_DIV_INIT: begin
                r_rem <= 64'd0;
                r_quo <= 64'd0;
                r_cnt <= 7'd0;
            end
            DC_DIV_STEP: begin
                if (!w_sub[64]) begin
                    r_rem <= w_sub[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
            end
            DC_GCD_NEXT: begin
                r_x <= r_y;
                r_y <= r_rem;
            end
            DC_QNUM: begin
                r_gnum <= r_quo;
                r_rem  <= 64'd0;
                r_quo  <= 64'd0;
                r_cnt  <= 7'd0;
            end
            DC_QDEN: begin
                r_cst <= (r_quo > 64'h7FFF_FFFF_FFFF_FFFF) ? ST_OVF
                       : (w_cneg ? (r_gnum > 64'h8000_0000_0000_0000)
                                 : (r_gnum > 64'h7FFF_FFFF_FFFF_FFFF)) ? ST_OVF : ST_OK;
                unique case (i_ctl.dst)
                    DST_A: begin
                        r_a_neg <= w_cneg;
                        r_a_num <= r_gnum;
                        r_a_den <= r_quo;
                    end
                    DST_B: begin
                        r_b_neg <= w_cneg;
                        r_b_num <= r_gnum;
                        r_b_den <= r_quo;
                    end
                    default: begin
                        r_r_neg <= w_cneg;
                        r_r_num <= r_gnum;
                        r_r_den <= r_quo;
                    end
                endcase
            end
            DC_MUL_P: begin
                r_q    <= w_prod;
                r_qneg <= 1'b0;
            end
            DC_MUL_Q: begin
                r_t1 <= w_prod;
                if (i_ctl.op == OP_MUL || i_ctl.op == OP_DIV) begin
                    r_p    <= w_prod;
                    r_pneg <= r_a_neg != r_b_neg;
                end
            end
            DC_MUL_R: begin
                if (r_a_neg == w_n2) begin
                    r_pneg <= r_a_neg;
                    r_p    <= r_t1 + w_prod;
                end else if (r_t1 >= w_prod) begin
                    r_pneg <= r_a_neg;
                    r_p    <= r_t1 - w_prod;
                end else begin
                    r_pneg <= w_n2;
                    r_p    <= w_prod - r_t1;
                end
            end
            DC_NEGATE: begin
                r_r_neg <= !r_a_neg && r_a_num != 64'd0;
                r_r_num <= r_a_num;
                r_r_den <= r_a_den;
            end
            default: begin
            end
        endcase
    end

    // divider operands: in gcd phase x % y, in quotient phase p/g then q/g
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == DC_GCD_INIT) begin
            r_dvd <= r_p;
            r_dvs <= r_q;
        end else if (i_ctl.cmd == DC_GCD_NEXT) begin
            r_dvd <= r_y;
            r_dvs <= r_rem;
        end else if (i_ctl.cmd == DC_QNUM) begin
            r_dvd <= r_q;
        end else if (i_ctl.cmd == DC_DIV_INIT && r_y == 64'd0) begin
            r_dvd <= r_p;
            r_dvs <= r_x;
        end
    end

    assign o_sts.y_zero   = (r_y == 64'd0);
    assign o_sts.g_zero   = (r_x == 64'd0);
    assign o_sts.div_done = (r_cnt == 7'd64);
    assign o_sts.canon_st = r_cst;
    assign o_res_num = r_r_neg ? $signed(64'd0 - r_r_num) : $signed(r_r_num);
    assign o_res_den = r_r_den[62:0];
endmodule

// ----- hdl/rau_ctrl.sv -----
// rau_ctrl: sequencer for canon of operands, products and final canon.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [2:0]      i_req_type,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_status,
    input  rau_pkg::t_sts   i_sts,
    output rau_pkg::t_ctl   o_ctl
);
    import rau_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_GINIT  = 8'b00000010,
        S_GTEST  = 8'b00000100,
        S_GDIV   = 8'b00001000,
        S_QDIV   = 8'b00010000,
        S_CHECK  = 8'b00100000,
        S_MUL    = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    t_dst   r_dst, n_dst;
    t_op    r_op, n_op;
    logic [1:0] r_mstep, n_mstep;
    logic       r_qph, n_qph;
    logic       r_inv, n_inv;
    logic [1:0] r_st, n_st;
    logic       r_ov, n_ov;

    assign o_in_ready  = (r_state == S_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_status    = r_st;

    always_comb begin
        n_state = r_state;
        n_dst   = r_dst;
        n_op    = r_op;
        n_mstep = r_mstep;
        n_qph   = r_qph;
        n_inv   = r_inv;
        n_st    = r_st;
        n_ov    = r_ov;
        o_ctl.cmd = DC_NOP;
        o_ctl.dst = r_dst;
        o_ctl.op  = r_op;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_ov) begin
                    n_op  = t_op'(i_req_type);
                    n_dst = DST_A;
                    n_inv = 1'b0;
                    if (i_req_type > OP_NEG) begin
                        n_st  = ST_UNDEF;
                        n_ov  = 1'b1;
                    end else begin
                        o_ctl.cmd = DC_LOAD_A;
                        n_state = S_GINIT;
                    end
                end
            end
            S_GINIT: begin
                o_ctl.cmd = DC_GCD_INIT;
                n_state = S_GTEST;
            end
            S_GTEST: begin
                if (i_sts.y_zero) begin
                    if (i_sts.g_zero) begin
                        n_st = ST_UNDEF;
                        n_ov = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.cmd = DC_DIV_INIT;
                        n_state = S_QDIV;
                        n_qph = 1'b0;
                    end
                end else begin
                    o_ctl.cmd = DC_DIV_INIT;
                    n_state = S_GDIV;
                end
            end
            S_GDIV: begin
                if (i_sts.div_done) begin
                    o_ctl.cmd = DC_GCD_NEXT;
                    n_state = S_GTEST;
                end else begin
                    o_ctl.cmd = DC_DIV_STEP;
                end
            end
            S_QDIV: begin
                if (i_sts.div_done) begin
                    if (!r_qph) begin
                        o_ctl.cmd = DC_QNUM;
                        n_qph = 1'b1;
                    end else begin
                        o_ctl.cmd = DC_QDEN;
                        n_state = S_CHECK;
                    end
                end else begin
                    o_ctl.cmd = DC_DIV_STEP;
                end
            end
            S_CHECK: begin
                if (i_sts.canon_st != ST_OK) begin
                    n_st = i_sts.canon_st;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    unique case (r_dst)
                        DST_A: begin
                            if (r_op == OP_NEG) begin
                                o_ctl.cmd = DC_NEGATE;
                                n_state = S_DONE;
                            end else begin
                                o_ctl.cmd = DC_LOAD_B;
                                n_dst = DST_B;
                                n_state = S_GINIT;
                            end
                        end
                        DST_B: begin
                            if (r_op == OP_DIV && !r_inv) begin
                                o_ctl.cmd = DC_LOAD_INV;
                                n_inv = 1'b1;
                                n_state = S_GINIT;
                            end else begin
                                n_mstep = 2'd0;
                                n_state = S_MUL;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                unique case (r_mstep)
                    2'd0: o_ctl.cmd = DC_MUL_P;
                    2'd1: o_ctl.cmd = DC_MUL_Q;
                    default: o_ctl.cmd = DC_MUL_R;
                endcase
                n_mstep = r_mstep + 2'd1;
                if (r_mstep == 2'd2 ||
                    (r_mstep == 2'd1 && (r_op == OP_MUL || r_op == OP_DIV))) begin
                    n_dst = DST_R;
                    n_state = S_GINIT;
                end
            end
            S_DONE: begin
                n_st = ST_OK;
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_dst   <= DST_A;
            r_op    <= OP_ADD;
            r_mstep <= 2'd0;
            r_qph   <= 1'b0;
            r_inv   <= 1'b0;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_dst   <= n_dst;
            r_op    <= n_op;
            r_mstep <= n_mstep;
            r_qph   <= n_qph;
            r_inv   <= n_inv;
            r_st    <= n_st;
        end
    end
endmodule

// ----- hdl/rational_arith_unit.sv -----
// rational_arith_unit: top level, joins controller and datapath.
// Depends on rau_pkg, rau_if, rau_ctrl, rau_datapath.
//   channel | dir | fields
//   i_req   | in  | req_type, a_num, a_den, b_num, b_den
//   o_res   | out | res_num, res_den, status
// One beat at a time. Each canon is a Euclid loop of restoring divisions in one shared
// divider, plus two quotient divisions, with up to four canons per item.
// Synchronous active-low reset idles the controller. A result waits for its ready.
module rational_arith_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);
    import rau_pkg::*;

    t_ctl       w_ctl;
    t_sts       w_sts;
    logic signed [63:0] w_num;
    logic [62:0] w_den;
    logic [1:0]  w_st;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_req_type (i_req.req_type),
        .o_out_valid(o_res.valid),
        .i_out_ready(o_res.ready),
        .o_status   (w_st),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    rau_datapath u_dp (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_a_num    (i_req.a_num),
        .i_a_den    (i_req.a_den),
        .i_b_num    (i_req.b_num),
        .i_b_den    (i_req.b_den),
        .o_sts      (w_sts),
        .o_res_num  (w_num),
        .o_res_den  (w_den)
    );

    assign o_res.status  = w_st;
    assign o_res.res_num = (w_st == ST_OK) ? w_num : 64'sd0;
    assign o_res.res_den = (w_st == ST_OK) ? w_den : 63'd0;
endmodule

// ----- sim/rational_arith_unit_test.sv -----
// rational_arith_unit_test: self-checking bench for the rational arithmetic unit.
// Directed rows then random fraction pairs, checked against an in-bench predictor.
// Depends on rau_pkg, rau_if and rational_arith_unit.
`timescale 1ns / 1ps

module rational_arith_unit_test;
    import rau_pkg::*;

    localparam logic [2:0] OP_RSV_LO = 3'd5;
    localparam logic [2:0] OP_RSV_HI = 3'd7;
    localparam logic [63:0] DEN_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] OPND_MASK = 64'hFFFF_FFFF;
    localparam logic [31:0] MIN_INT   = 32'h8000_0000;
    localparam logic [31:0] MAX_INT   = 32'h7FFF_FFFF;
    localparam int RANDOM_ITEMS = 1880;

    typedef struct {
        bit        neg;
        bit [63:0] num;
        bit [63:0] den;
    } frac_t;

    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic [1:0]         st;
    } quot_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] an, ad, bn, bd;
        bit          fixed;
        quot_t       want;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors = 0;
    bit   quiet = 1'b0;
    quot_t pending_q[$];

    rau_req_if req_if();
    rau_res_if res_if();

    rational_arith_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
        bit [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic void reduce(input bit pneg, input bit [63:0] pm, input bit qneg,
                                   input bit [63:0] qm, output frac_t r,
                                   output logic [1:0] st);
        bit [63:0] g;
        g = gcd64(pm, qm);
        r = '{neg: 1'b0, num: 64'd0, den: 64'd0};
        if (g == 0) begin
            st = ST_UNDEF;
            return;
        end
        r.num = pm / g;
        r.den = qm / g;
        r.neg = (pneg != (qneg && qm != 0)) && r.num != 0;
        if (r.den > DEN_LIMIT || (r.neg ? r.num > NEG_LIMIT : r.num > DEN_LIMIT))
            st = ST_OVF;
        else
            st = ST_OK;
    endfunction

    function automatic void split(input logic [31:0] raw, output bit neg,
                                  output bit [63:0] mag);
        bit [63:0] v;
        v = {32'd0, raw};
        neg = raw[31];
        mag = neg ? ((64'd0 - v) & OPND_MASK) : v;
    endfunction

    function automatic void load_frac(input logic [31:0] n, input logic [31:0] d,
                                      output frac_t f, output logic [1:0] st);
        bit nn, dn;
        bit [63:0] nm, dm;
        split(n, nn, nm);
        split(d, dn, dm);
        reduce(nn, nm, dn, dm, f, st);
    endfunction

    function automatic quot_t rational_result(logic [2:0] op, logic [31:0] an,
                                              logic [31:0] ad, logic [31:0] bn,
                                              logic [31:0] bd);
        frac_t a, b, r, inv;
        logic [1:0] st;
        bit pneg, n1, n2;
        bit [63:0] pm, qm, t1, t2;
        quot_t e;
        r = '{neg: 1'b0, num: 64'd0, den: 64'd0};
        st = ST_OK;
        if (op > OP_NEG) begin
            st = ST_UNDEF;
        end else begin
            load_frac(an, ad, a, st);
            if (st == ST_OK && op == OP_NEG) begin
                r = a;
                r.neg = !a.neg && a.num != 0;
            end else if (st == ST_OK) begin
                load_frac(bn, bd, b, st);
                if (st == ST_OK && op == OP_DIV) begin
                    reduce(b.den != 0, b.den, !b.neg && b.num != 0, b.num, inv, st);
                    b = inv;
                end
                if (st == ST_OK) begin
                    qm = a.den * b.den;
                    if (op == OP_MUL || op == OP_DIV) begin
                        pneg = a.neg != b.neg;
                        pm = a.num * b.num;
                    end else begin
                        t1 = a.num * b.den;
                        t2 = b.num * a.den;
                        n1 = a.neg;
                        n2 = b.neg != (op == OP_SUB);
                        if (n1 == n2) begin
                            pneg = n1;
                            pm = t1 + t2;
                        end else if (t1 >= t2) begin
                            pneg = n1;
                            pm = t1 - t2;
                        end else begin
                            pneg = n2;
                            pm = t2 - t1;
                        end
                    end
                    reduce(pneg, pm, 1'b0, qm, r, st);
                end
            end
        end
        if (st != ST_OK) begin
            e.num = '0;
            e.den = '0;
        end else begin
            e.num = r.neg ? (64'd0 - r.num) : r.num;
            e.den = r.den[62:0];
        end
        e.st = st;
        return e;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        errors++;
    endtask

    function automatic int gap_len();
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    task automatic send(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                        logic [31:0] bn, logic [31:0] bd, quot_t want);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.a_num    <= an;
        req_if.a_den    <= ad;
        req_if.b_num    <= bn;
        req_if.b_den    <= bd;
        do @(posedge i_clk); while (!req_if.ready);
        pending_q.push_back(want);
    endtask

    function automatic logic [31:0] pick_value();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 32'($signed($urandom_range(0, 128)) - 64);
        if (p < 90) return 32'($signed($urandom_range(0, 65535)) - 32768);
        if (p < 94) return $urandom_range(0, 1) ? MIN_INT : MAX_INT;
        return $urandom;
    endfunction

    // result side: random stalls, sampled at the rising edge
    int stall = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            res_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                  : $urandom_range(0, 3);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        quot_t w;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected beat", {res_if.res_num}, 64'd0);
            end else begin
                w = pending_q.pop_front();
                if (res_if.res_num !== w.num) report("res_num", res_if.res_num, w.num);
                if (res_if.res_den !== w.den)
                    report("res_den", {1'b0, res_if.res_den}, {1'b0, w.den});
                if (res_if.status !== w.st)
                    report("status", {62'd0, res_if.status}, {62'd0, w.st});
            end
        end
    end

    initial begin
        #1500ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        row_t rows[$];
        row_t rw;
        quot_t w;
        logic [2:0] op;
        req_if.valid    <= 1'b0;
        req_if.req_type <= '0;
        req_if.a_num    <= '0;
        req_if.a_den    <= '0;
        req_if.b_num    <= '0;
        req_if.b_den    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1'b0, '{0, 0, ST_OK}},
            '{OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3, 1'b0, '{0, 0, ST_OK}},
            '{OP_MUL, -32'sd6, 32'd4, 32'd2, -32'sd9, 1'b0, '{0, 0, ST_OK}},
            '{OP_DIV, 32'd3, 32'd4, -32'sd5, 32'd7, 1'b0, '{0, 0, ST_OK}},
            '{OP_NEG, 32'd10, -32'sd4, 32'd0, 32'd0, 1'b0, '{0, 0, ST_OK}},
            '{OP_ADD, 32'd0, 32'd0, 32'd1, 32'd1, 1'b1, '{0, 0, ST_UNDEF}},
            '{OP_MUL, 32'd1, 32'd1, 32'd0, 32'd0, 1'b1, '{0, 0, ST_UNDEF}},
            '{OP_DIV, 32'd1, 32'd1, 32'd0, 32'd0, 1'b1, '{0, 0, ST_UNDEF}},
            '{OP_NEG, 32'd0, 32'd0, 32'd5, 32'd5, 1'b1, '{0, 0, ST_UNDEF}},
            '{OP_RSV_LO, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1, '{0, 0, ST_UNDEF}},
            '{3'd6, 32'd3, 32'd2, 32'd1, 32'd1, 1'b1, '{0, 0, ST_UNDEF}},
            '{OP_RSV_HI, MAX_INT, MIN_INT, 32'd1, 32'd1, 1'b1, '{0, 0, ST_UNDEF}},
            '{OP_ADD, 32'd5, 32'd0, 32'd1, 32'd1, 1'b1, '{1, 0, ST_OK}},
            '{OP_NEG, 32'd5, 32'd0, 32'd0, 32'd0, 1'b1, '{-1, 0, ST_OK}},
            '{OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5, 1'b1, '{-1, 0, ST_OK}},
            '{OP_NEG, 32'd0, -32'sd7, 32'd0, 32'd0, 1'b1, '{0, 1, ST_OK}},
            '{OP_NEG, MIN_INT, 32'd1, 32'd0, 32'd0, 1'b1, '{64'sd2147483648, 1, ST_OK}},
            '{OP_MUL, MAX_INT, 32'd1, MAX_INT, 32'd1, 1'b0, '{0, 0, ST_OK}},
            '{OP_MUL, MIN_INT, 32'd1, MIN_INT, 32'd1, 1'b0, '{0, 0, ST_OK}},
            '{OP_ADD, MIN_INT, MAX_INT, MIN_INT, MAX_INT, 1'b0, '{0, 0, ST_OK}},
            '{OP_SUB, MIN_INT, MIN_INT, MAX_INT, MIN_INT, 1'b0, '{0, 0, ST_OK}},
            '{OP_DIV, MAX_INT, MIN_INT, MIN_INT, MAX_INT, 1'b0, '{0, 0, ST_OK}},
            '{OP_DIV, 32'd0, 32'd3, 32'd0, 32'd3, 1'b0, '{0, 0, ST_OK}},
            '{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0,
              '{0, 0, ST_OK}}
        };
        foreach (rows[i]) begin
            rw = rows[i];
            w = rw.fixed ? rw.want : rational_result(rw.op, rw.an, rw.ad, rw.bn, rw.bd);
            send(rw.op, rw.an, rw.ad, rw.bn, rw.bd, w);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            logic [31:0] an, ad, bn, bd;
            if (n % 300 == 150) quiet = 1'b1;
            if (n % 300 == 200) quiet = 1'b0;
            if (n == RANDOM_ITEMS / 2) begin
                // hold off until the unit has drained
                req_if.valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
            op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(OP_RSV_LO, OP_RSV_HI))
                                              : 3'($urandom_range(OP_ADD, OP_NEG));
            an = pick_value();
            ad = pick_value();
            bn = pick_value();
            bd = pick_value();
            send(op, an, ad, bn, bd, rational_result(op, an, ad, bn, bd));
        end
        req_if.valid <= 1'b0;
        quiet = 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
